### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PIDIA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define PIDIA_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

### rtl/pidia_pkg.sv
// ----------------------------------------------------------------------------
// pidia_pkg
// Types and constants shared by the PID controller modules.
// ----------------------------------------------------------------------------
package pidia_pkg;

	localparam int FIFO_DEPTH_DEF = 4;

	typedef enum logic {
		MODE_INCR = 1'b0,
		MODE_ABS  = 1'b1
	} mode_t;

	typedef enum logic [3:0] {
		REG_GAIN_PROP    = 4'd0,
		REG_GAIN_INTEG   = 4'd1,
		REG_GAIN_DERIV   = 4'd2,
		REG_GAIN_FEEDFWD = 4'd3,
		REG_OUT_UPPER    = 4'd4,
		REG_OUT_LOWER    = 4'd5,
		REG_INTEG_UPPER  = 4'd6,
		REG_INTEG_LOWER  = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] gain_prop;
		logic signed [15:0] gain_integ;
		logic signed [15:0] gain_deriv;
		logic signed [15:0] gain_feedfwd;
		logic signed [15:0] out_upper;
		logic signed [15:0] out_lower;
		logic signed [23:0] integ_upper;
		logic signed [23:0] integ_lower;
	} cfg_t;

	// One classified request: the four multiplier operands for the back end.
	typedef struct packed {
		mode_t              mode;
		logic signed [17:0] op_p;
		logic signed [23:0] op_i;
		logic signed [18:0] op_d;
		logic signed [15:0] op_f;
	} q_entry_t;

endpackage

### rtl/pid_controller_incremental_absolute.sv
// A request accepted on the input goes through the queue, stage 1 (products), stage 2
// (scaled sum) and the output register to out_valid. Throughput: one request per cycle while
// out_ready keeps up, set by the history loop in the output stage (add previous drive, clamp,
// store) and one pipelined multiplier set. The front end takes requests while the queue
// (FIFO_DEPTH entries) has room. Reset (arst_n low): errors, integral and previous drive zero;
// gains zero, limits at their widest; queue and pipeline empty.
// ----------------------------------------------------------------------------
// pid_controller_incremental_absolute
// PID controller with incremental and positional forms, Q8.8 gains.
// ----------------------------------------------------------------------------
module pid_controller_incremental_absolute #(
	parameter int FIFO_DEPTH = pidia_pkg::FIFO_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_wr_en,
	input  logic [3:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic signed [15:0] measured,
	input  logic signed [15:0] setpoint,
	input  logic signed [15:0] feedforward,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] drive,
	output logic               clamped
);

	localparam int Q_W = $bits(pidia_pkg::q_entry_t);

	pidia_pkg::cfg_t     cfg_q;
	pidia_pkg::q_entry_t front_entry, back_entry;
	logic [Q_W-1:0]      q_rd_data;
	logic                q_full, q_not_empty, q_pop, push;

	// Configuration registers. The user must write them only while idle; the block does not
	// enforce it, and the pipeline reads them directly. Indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop    <= '0;
			cfg_q.gain_integ   <= '0;
			cfg_q.gain_deriv   <= '0;
			cfg_q.gain_feedfwd <= '0;
			cfg_q.out_upper    <= 16'sh7FFF;
			cfg_q.out_lower    <= -16'sh8000;
			cfg_q.integ_upper  <= 24'sh7FFFFF;
			cfg_q.integ_lower  <= -24'sh800000;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pidia_pkg::REG_GAIN_PROP:    cfg_q.gain_prop    <= cfg_data[15:0];
				pidia_pkg::REG_GAIN_INTEG:   cfg_q.gain_integ   <= cfg_data[15:0];
				pidia_pkg::REG_GAIN_DERIV:   cfg_q.gain_deriv   <= cfg_data[15:0];
				pidia_pkg::REG_GAIN_FEEDFWD: cfg_q.gain_feedfwd <= cfg_data[15:0];
				pidia_pkg::REG_OUT_UPPER:    cfg_q.out_upper    <= cfg_data[15:0];
				pidia_pkg::REG_OUT_LOWER:    cfg_q.out_lower    <= cfg_data[15:0];
				pidia_pkg::REG_INTEG_UPPER:  cfg_q.integ_upper  <= cfg_data;
				pidia_pkg::REG_INTEG_LOWER:  cfg_q.integ_lower  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Front end: error history and integral advance at accept time, so the
	// queued entry carries ready-made multiplier operands.
	pidia_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.mode        (mode),
		.measured    (measured),
		.setpoint    (setpoint),
		.feedforward (feedforward),
		.entry       (front_entry)
	);

	pidia_fifo #(
		.WIDTH (Q_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_data   (q_rd_data)
	);

	assign back_entry = pidia_pkg::q_entry_t'(q_rd_data);

	// Back end: products, scaled sum, then previous-drive add and clamp.
	pidia_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_not_empty),
		.q_entry   (back_entry),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.drive     (drive),
		.clamped   (clamped)
	);

endmodule

### rtl/pidia_front.sv
// ----------------------------------------------------------------------------
// pidia_front
// Error history, integral update and operand selection per request.
// ----------------------------------------------------------------------------
module pidia_front (
	input  logic                clk,
	input  logic                arst_n,
	input  pidia_pkg::cfg_t     cfg,
	input  logic                push,
	input  logic                mode,
	input  logic signed [15:0]  measured,
	input  logic signed [15:0]  setpoint,
	input  logic signed [15:0]  feedforward,
	output pidia_pkg::q_entry_t entry
);

	logic signed [16:0] e1_q, e2_q;
	logic signed [23:0] integ_q;

	logic signed [16:0] err;
	logic signed [17:0] d1;
	logic signed [18:0] d2;
	logic signed [24:0] acc;
	logic signed [23:0] integ_nxt;

	always_comb begin
		err = 17'(setpoint) - 17'(measured);
		d1  = 18'(err) - 18'(e1_q);
		d2  = 19'(err) - (19'(e1_q) <<< 1) + 19'(e2_q);
		acc = 25'(integ_q) + 25'(err);
		// lower test first: with crossed limits, below lower gives lower, else upper
		if (acc < 25'(cfg.integ_lower))
			integ_nxt = cfg.integ_lower;
		else if (acc > 25'(cfg.integ_upper))
			integ_nxt = cfg.integ_upper;
		else
			integ_nxt = acc[23:0];
	end

	always_comb begin
		entry.mode = pidia_pkg::mode_t'(mode);
		entry.op_f = feedforward;
		if (mode == pidia_pkg::MODE_ABS) begin
			entry.op_p = 18'(err);
			entry.op_i = integ_nxt;
			entry.op_d = 19'(d1);
		end else begin
			entry.op_p = d1;
			entry.op_i = 24'(err);
			entry.op_d = d2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_q    <= '0;
			e2_q    <= '0;
			integ_q <= '0;
		end else if (push) begin
			e1_q <= err;
			e2_q <= e1_q;
			if (mode == pidia_pkg::MODE_ABS)
				integ_q <= integ_nxt;
		end
	end

endmodule

### rtl/pidia_fifo.sv
// ----------------------------------------------------------------------------
// pidia_fifo
// Small show-ahead queue between front and back end.
// ----------------------------------------------------------------------------
module pidia_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pidia_pkg::FIFO_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/pidia_back.sv
// ----------------------------------------------------------------------------
// pidia_back
// Multiply, sum and scale, then add history, clamp and hold the result.
// ----------------------------------------------------------------------------
module pidia_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pidia_pkg::cfg_t     cfg,
	input  logic                q_valid,
	input  pidia_pkg::q_entry_t q_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  drive,
	output logic                clamped
);

	logic               valid_s1, valid_s2, out_valid_q;
	pidia_pkg::mode_t   mode_s1, mode_s2;
	logic signed [33:0] prod_p_s1;
	logic signed [39:0] prod_i_s1;
	logic signed [34:0] prod_d_s1;
	logic signed [31:0] prod_f_s1;
	logic signed [33:0] scaled_s2;
	logic signed [15:0] drive_q, prev_drive_q;
	logic               clamped_q;

	logic               adv_o, rdy_s2, adv_2, rdy_s1;
	logic signed [41:0] sum;
	logic signed [34:0] y;
	logic signed [15:0] y_clamp;
	logic               hit;

	assign adv_o  = valid_s2 && (!out_valid_q || out_ready);
	assign rdy_s2 = !valid_s2 || adv_o;
	assign adv_2  = valid_s1 && rdy_s2;
	assign rdy_s1 = !valid_s1 || adv_2;
	assign pop    = q_valid && rdy_s1;

	assign sum = 42'(prod_p_s1) + 42'(prod_i_s1) + 42'(prod_d_s1) + 42'(prod_f_s1);

	always_comb begin
		y   = 35'(scaled_s2) + ((mode_s2 == pidia_pkg::MODE_INCR) ? 35'(prev_drive_q) : '0);
		hit = 1'b1;
		// upper test first: with crossed limits, above upper gives upper, else lower
		if (y > 35'(cfg.out_upper))
			y_clamp = cfg.out_upper;
		else if (y < 35'(cfg.out_lower))
			y_clamp = cfg.out_lower;
		else begin
			y_clamp = y[15:0];
			hit     = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mode_s1   <= q_entry.mode;
			prod_p_s1 <= $signed(cfg.gain_prop) * $signed(q_entry.op_p);
			prod_i_s1 <= $signed(cfg.gain_integ) * $signed(q_entry.op_i);
			prod_d_s1 <= $signed(cfg.gain_deriv) * $signed(q_entry.op_d);
			prod_f_s1 <= $signed(cfg.gain_feedfwd) * $signed(q_entry.op_f);
		end
		if (adv_2) begin
			mode_s2   <= mode_s1;
			scaled_s2 <= sum[41:8];  // floor of sum / 256
		end
		if (adv_o) begin
			drive_q   <= y_clamp;
			clamped_q <= hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
			prev_drive_q <= '0;
		end else begin
			if (rdy_s1)
				valid_s1 <= q_valid;
			if (rdy_s2)
				valid_s2 <= valid_s1;
			if (!out_valid_q || out_ready)
				out_valid_q <= valid_s2;
			if (adv_o && mode_s2 == pidia_pkg::MODE_INCR)
				prev_drive_q <= y_clamp;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign clamped   = clamped_q;

endmodule

### rtl/pidia_checker.sv
// ----------------------------------------------------------------------------
// pidia_checker
// Port-level checks on request and result flow of the PID controller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pidia_checker #(
	parameter int FIFO_DEPTH = pidia_pkg::FIFO_DEPTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] drive,
	input logic               clamped
);

	localparam int CAP   = FIFO_DEPTH + 3;  // queue plus three back-end stages
	localparam int CNT_W = $clog2(CAP + 2);
	localparam logic [CNT_W-1:0] Q_FULL = CNT_W'(FIFO_DEPTH);

	logic [CNT_W-1:0] outstanding_q;
	logic             in_acc, out_acc, stall;
	logic [16:0]      res;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign stall   = out_valid && !out_ready;
	assign res     = {drive, clamped};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else if (in_acc && !out_acc)
			outstanding_q <= outstanding_q + 1'b1;
		else if (out_acc && !in_acc)
			outstanding_q <= outstanding_q - 1'b1;
	end

	`PIDIA_ASSERT(a_out_hold, clk, arst_n, stall |=> out_valid && $stable(res), "result not held")
	`PIDIA_NEVER(a_no_invent, clk, arst_n, out_valid && outstanding_q == '0, "result without request")
	`PIDIA_NEVER(a_cap, clk, arst_n, outstanding_q > CNT_W'(CAP), "too many requests in flight")
	`PIDIA_ASSERT(a_ready, clk, arst_n, !in_ready |-> outstanding_q >= Q_FULL, "stall with queue room")

endmodule

bind pid_controller_incremental_absolute pidia_checker #(
	.FIFO_DEPTH (FIFO_DEPTH)
) u_pidia_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the incremental / absolute PID controller. Requests
// are queued by the stimulus process, sent by a clocked driver that predicts
// each result at acceptance, and checked in order by a clocked monitor.
// ----------------------------------------------------------------------------
module tb_top;
	import pidia_pkg::*;

	localparam int         WATCHDOG_LIMIT  = 2000;  // cycles with no transfer
	localparam int         HOLD_CYCLES     = 80;    // long receiver back-off
	localparam int         SETTLE_CYCLES   = 8;     // longer than the pipeline latency
	localparam int         RAND_PHASES     = 9;
	localparam int         REQS_PER_PHASE  = 150;
	localparam logic [3:0] IDX_UNUSED_BASE = 4'd8;  // indexes 8..15 decode to nothing

	typedef struct {
		mode_t              md;
		logic signed [15:0] meas;
		logic signed [15:0] sp;
		logic signed [15:0] ff;
	} ctl_req_t;

	typedef struct {
		logic signed [15:0] drive;
		logic               clamped;
	} ctl_result_t;

	// DUT pins; every input starts at a known value
	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [3:0]         cfg_index   = '0;
	logic [23:0]        cfg_data    = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               mode        = MODE_INCR;
	logic signed [15:0] measured    = '0;
	logic signed [15:0] setpoint    = '0;
	logic signed [15:0] feedforward = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic signed [15:0] drive;
	logic               clamped;

	// request traffic and result bookkeeping
	ctl_req_t    req_pending_q[$];
	ctl_req_t    cur_req;
	ctl_result_t drive_expect_q[$];
	int          sent_cnt  = 0;
	int          seen_cnt  = 0;
	int          fail_cnt  = 0;
	int          quiet_cnt = 0;

	// flow control knobs, set by the stimulus between phases (hold_ack, hold_left kept by the monitor)
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req      = 0;
	int hold_ack      = 0;
	int hold_left     = 0;

	// shadow of the controller: registers at reset values
	logic signed [15:0] k_prop   = '0;
	logic signed [15:0] k_integ  = '0;
	logic signed [15:0] k_deriv  = '0;
	logic signed [15:0] k_ff     = '0;
	logic signed [15:0] drv_hi   = 16'sh7FFF;
	logic signed [15:0] drv_lo   = 16'sh8000;
	logic signed [23:0] integ_hi = 24'sh7FFFFF;
	logic signed [23:0] integ_lo = 24'sh800000;
	// shadow of the controller: loop state
	logic signed [16:0] err_hist[3] = '{default: '0};
	int                 ring_pos    = 0;
	logic signed [23:0] integ_acc   = '0;
	logic signed [15:0] last_drive  = '0;

	pid_controller_incremental_absolute dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.measured   (measured),
		.setpoint   (setpoint),
		.feedforward(feedforward),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive      (drive),
		.clamped    (clamped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Next drive value for one request; advances the shadow loop state.
	// All products are kept in 64 bits, so nothing wraps before the shift.
	function automatic ctl_result_t predict_drive(ctl_req_t r);
		longint      e, e1, e2, s, y, acc;
		ctl_result_t res;
		e = longint'(r.sp) - longint'(r.meas);
		err_hist[ring_pos] = e[16:0];
		e1 = err_hist[(ring_pos + 2) % 3];
		e2 = err_hist[(ring_pos + 1) % 3];
		if (r.md == MODE_INCR) begin
			s = longint'(k_prop) * (e - e1) + longint'(k_integ) * e
				+ longint'(k_deriv) * (e - 2 * e1 + e2) + longint'(k_ff) * longint'(r.ff);
			y = (s >>> 8) + longint'(last_drive);
		end else begin
			// integral clamp: lower test first; crossed limits give lower when below it, else upper
			acc = longint'(integ_acc) + e;
			if (acc < longint'(integ_lo))
				acc = integ_lo;
			else if (acc > longint'(integ_hi))
				acc = integ_hi;
			integ_acc = acc[23:0];
			s = longint'(k_prop) * e + longint'(k_integ) * longint'(integ_acc)
				+ longint'(k_deriv) * (e - e1) + longint'(k_ff) * longint'(r.ff);
			y = s >>> 8;
		end
		ring_pos = (ring_pos + 1) % 3;
		// output clamp: upper test first; crossed limits give upper when above it, else lower
		res.clamped = 1'b1;
		if (y > longint'(drv_hi))
			y = drv_hi;
		else if (y < longint'(drv_lo))
			y = drv_lo;
		else
			res.clamped = 1'b0;
		res.drive = y[15:0];
		if (r.md == MODE_INCR)
			last_drive = res.drive;
		return res;
	endfunction

	function automatic logic signed [15:0] sat16(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// mostly near center, sometimes full scale or a rail
	function automatic logic signed [15:0] rand_sample(int center, int spread);
		case ($urandom_range(9))
			0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1, 2:    return 16'($urandom);
			default: return sat16(center + int'($urandom_range(2 * spread)) - spread);
		endcase
	endfunction

	function automatic logic signed [15:0] rand_gain();
		case ($urandom_range(7))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return '0;
			3, 4:    return 16'($urandom);
			default: return 16'($urandom_range(1024)) - 16'sd512;  // within +/-2.0
		endcase
	endfunction

	// One register write, mirrored into the shadow. Only called while idle.
	task automatic write_reg(logic [3:0] idx, logic [23:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_GAIN_PROP:    k_prop   = data[15:0];
			REG_GAIN_INTEG:   k_integ  = data[15:0];
			REG_GAIN_DERIV:   k_deriv  = data[15:0];
			REG_GAIN_FEEDFWD: k_ff     = data[15:0];
			REG_OUT_UPPER:    drv_hi   = data[15:0];
			REG_OUT_LOWER:    drv_lo   = data[15:0];
			REG_INTEG_UPPER:  integ_hi = data;
			REG_INTEG_LOWER:  integ_lo = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic add_req(mode_t md, logic signed [15:0] m, logic signed [15:0] sp,
			logic signed [15:0] ff);
		ctl_req_t r;
		r.md   = md;
		r.meas = m;
		r.sp   = sp;
		r.ff   = ff;
		req_pending_q.push_back(r);
		sent_cnt++;
	endtask

	// Every queued request answered, then let the pipeline settle.
	task automatic drain();
		while (seen_cnt != sent_cnt)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus: two directed phases, then random phases with fresh settings
	// and a flow-control pattern that cycles through four settings.
	// ------------------------------------------------------------------------
	initial begin
		int                 ph, k, drift;
		logic signed [15:0] m, sp, hi16, lo16;
		logic signed [23:0] hi24, lo24;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// moderate gains, wide output limits, integral limits at +/-100000
		write_reg(REG_GAIN_PROP,    24'h000100);
		write_reg(REG_GAIN_INTEG,   24'h000040);
		write_reg(REG_GAIN_DERIV,   24'h000080);
		write_reg(REG_GAIN_FEEDFWD, 24'h000100);
		write_reg(REG_INTEG_UPPER,  24'd100000);
		write_reg(REG_INTEG_LOWER,  24'sd0 - 24'sd100000);
		add_req(MODE_INCR, 16'sd0,      16'sd0,      16'sd0);
		add_req(MODE_INCR, 16'sh8000,   16'sh7FFF,   16'sd0);      // largest positive error
		add_req(MODE_INCR, 16'sh7FFF,   16'sh8000,   16'sd0);      // largest negative error
		add_req(MODE_INCR, 16'sd0,      16'sd0,      16'sh7FFF);
		add_req(MODE_INCR, 16'sd0,      16'sd0,      16'sh8000);
		add_req(MODE_ABS,  16'sh8000,   16'sh7FFF,   16'sd0);
		add_req(MODE_ABS,  16'sh8000,   16'sh7FFF,   16'sd0);      // integral runs into upper
		add_req(MODE_ABS,  16'sh7FFF,   16'sh8000,   16'sh8000);
		add_req(MODE_ABS,  16'sh7FFF,   16'sh8000,   16'sh7FFF);
		add_req(MODE_ABS,  16'sh7FFF,   16'sh8000,   16'sd0);      // integral heads toward lower
		add_req(MODE_INCR, 16'sd100,    -16'sd100,   16'sd0);
		add_req(MODE_ABS,  16'sd0,      16'sd0,      16'sd0);
		drain();

		// rail gains (widest products) with both limit pairs crossed
		write_reg(REG_GAIN_PROP,    24'h007FFF);
		write_reg(REG_GAIN_INTEG,   24'hFF8000);
		write_reg(REG_GAIN_DERIV,   24'h007FFF);
		write_reg(REG_GAIN_FEEDFWD, 24'h008000);
		write_reg(REG_OUT_UPPER,    24'hFFFF9C);   // -100, below the lower limit
		write_reg(REG_OUT_LOWER,    24'h000064);   // +100
		write_reg(REG_INTEG_UPPER,  24'sd0 - 24'sd1000);
		write_reg(REG_INTEG_LOWER,  24'sd1000);
		write_reg(IDX_UNUSED_BASE, 24'hFFFFFF);   // no register behind this index
		add_req(MODE_INCR, 16'sh8000,   16'sh7FFF,   16'sh8000);
		add_req(MODE_INCR, 16'sh7FFF,   16'sh8000,   16'sh7FFF);
		add_req(MODE_INCR, 16'sd0,      16'sd0,      16'sd0);
		add_req(MODE_ABS,  16'sh8000,   16'sh7FFF,   16'sh7FFF);
		add_req(MODE_ABS,  16'sh7FFF,   16'sh8000,   16'sh8000);
		add_req(MODE_ABS,  16'sd0,      16'sd0,      16'sd0);
		add_req(MODE_ABS,  16'sd5,      16'sd3,      16'sd0);
		add_req(MODE_INCR, 16'sd3,      16'sd5,      16'sd0);
		drain();

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 69; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 69; end
				default: begin send_idle_pct = 7; recv_idle_pct = 7; end
			endcase

			// upper config bits of the 16-bit registers are don't-care; toggle them
			write_reg(REG_GAIN_PROP,    {8'($urandom), rand_gain()});
			write_reg(REG_GAIN_INTEG,   {8'($urandom), rand_gain()});
			write_reg(REG_GAIN_DERIV,   {8'($urandom), rand_gain()});
			write_reg(REG_GAIN_FEEDFWD, {8'($urandom), rand_gain()});
			case ($urandom_range(3))
				0: begin hi16 = 16'sh7FFF; lo16 = 16'sh8000; end
				1: begin
					hi16 = 16'($urandom_range(3000));
					lo16 = 16'sd0 - 16'($urandom_range(3000));
				end
				2: begin hi16 = 16'($urandom); lo16 = 16'($urandom); end   // may cross
				default: begin
					hi16 = 16'($urandom_range(200)) - 16'sd100;
					lo16 = hi16;                                           // pinned output
				end
			endcase
			write_reg(REG_OUT_UPPER, {8'($urandom), hi16});
			write_reg(REG_OUT_LOWER, {8'($urandom), lo16});
			case ($urandom_range(3))
				0: begin hi24 = 24'sh7FFFFF; lo24 = 24'sh800000; end
				1: begin
					hi24 = 24'($urandom_range(1 << 20));
					lo24 = 24'sd0 - 24'($urandom_range(1 << 20));
				end
				2: begin hi24 = 24'($urandom); lo24 = 24'($urandom); end
				default: begin
					hi24 = 24'($urandom_range(4000));
					lo24 = 24'sd0 - 24'($urandom_range(4000));
				end
			endcase
			write_reg(REG_INTEG_UPPER, hi24);
			write_reg(REG_INTEG_LOWER, lo24);
			write_reg(IDX_UNUSED_BASE + 4'($urandom_range(7)), 24'($urandom));

			// a steady error bias walks the integral into its limits
			case ($urandom_range(2))
				0:       drift = 0;
				1:       drift = 250;
				default: drift = -250;
			endcase

			// back-pressure: receiver stops for a long stretch while the
			// sender keeps offering, so the input queue fills and stalls
			if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req      = hold_req + 1;
			end

			for (k = 0; k < REQS_PER_PHASE; k++) begin
				m  = rand_sample(0, 2000);
				sp = rand_sample(int'(m) + drift, 300);
				add_req($urandom_range(1) ? MODE_ABS : MODE_INCR, m, sp, rand_sample(0, 1000));
			end
			drain();
		end

		if (drive_expect_q.size() != 0)
			fail_cnt++;
		if (fail_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: predicts each request as it is accepted, then offers the next
	// one (or idles) once the current one is gone.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				drive_expect_q.push_back(predict_drive(cur_req));
			if (!in_valid || in_ready) begin
				if (req_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_req = req_pending_q.pop_front();
					in_valid    <= 1'b1;
					mode        <= cur_req.md;
					measured    <= cur_req.meas;
					setpoint    <= cur_req.sp;
					feedforward <= cur_req.ff;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: in-order check against the oldest expected drive; also owns
	// out_ready, including the long hold-off.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		ctl_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (drive_expect_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: unexpected result drive=%0d clamped=%0b",
							$realtime, drive, clamped);
				end else begin
					want = drive_expect_q.pop_front();
					seen_cnt++;
					if (drive !== want.drive || clamped !== want.clamped) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("%0t: result %0d: expected drive=%0d clamped=%0b, got drive=%0d clamped=%0b",
								$realtime, seen_cnt, want.drive, want.clamped, drive, clamped);
					end
				end
			end
			if (hold_ack != hold_req) begin
				hold_ack  = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: too long without any transfer on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cnt <= 0;
			else
				quiet_cnt <= quiet_cnt + 1;
			if (quiet_cnt >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

endmodule

### sim.f
+incdir+rtl
rtl/pidia_pkg.sv
rtl/pidia_front.sv
rtl/pidia_fifo.sv
rtl/pidia_back.sv
rtl/pid_controller_incremental_absolute.sv
rtl/pidia_checker.sv
bench/tb_top.sv
